@@ hdl/deq_pkg.sv @@
package deq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int TOTAL_W       = 5;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_NOP        = 3'd4;

  localparam logic [1:0] ROW_HOLD   = 2'd0;
  localparam logic [1:0] ROW_INSERT = 2'd1;
  localparam logic [1:0] ROW_REMOVE = 2'd2;
  localparam logic [1:0] ROW_APPEND = 2'd3;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] data;
  } row_ctrl_t;

endpackage

@@ hdl/deq_cell.sv @@
module deq_cell #(
  parameter int CNT_W      = 5,
  parameter int CELL_INDEX = 0
) (
  input  logic                               clk,
  input  deq_pkg::row_ctrl_t                 ctrl,
  input  logic [CNT_W-1:0]                   count,
  input  logic signed [deq_pkg::DATA_W-1:0]  lower_value,
  input  logic signed [deq_pkg::DATA_W-1:0]  upper_value,
  output logic signed [deq_pkg::DATA_W-1:0]  value
);

  logic signed [deq_pkg::DATA_W-1:0] value_r;
  logic signed [deq_pkg::DATA_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    case (ctrl.op)
      deq_pkg::ROW_INSERT: value_nxt = lower_value;
      deq_pkg::ROW_REMOVE: value_nxt = upper_value;
      deq_pkg::ROW_APPEND: begin
        if (count == CNT_W'(CELL_INDEX)) value_nxt = ctrl.data;
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

@@ hdl/deq_row.sv @@
module deq_row #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  deq_pkg::row_ctrl_t                 ctrl,
  input  logic [CNT_W-1:0]                   count,
  output logic signed [deq_pkg::DATA_W-1:0]  head_value
);

  logic signed [deq_pkg::DATA_W-1:0] cell_value [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::DATA_W-1:0] lower;
    logic signed [deq_pkg::DATA_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = ctrl.data;
    end else begin : g_mid_lo
      assign lower = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_value[i];
    end else begin : g_mid_hi
      assign upper = cell_value[i+1];
    end

    deq_cell #(
      .CNT_W      (CNT_W),
      .CELL_INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .lower_value (lower),
      .upper_value (upper),
      .value       (cell_value[i])
    );
  end

  assign head_value = cell_value[0];

endmodule

@@ hdl/double_ended_queue.sv @@
// Latency: a result appears on the cycle after its command transaction.
// Throughput: one command per cycle while out_ready is high; two rows
// of DEPTH cells, one aligned to the front, one to the back, shift or load.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; cell contents are not cleared.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_cmd,
  input  logic signed [deq_pkg::DATA_W-1:0]  in_data_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ok,
  output logic signed [deq_pkg::DATA_W-1:0]  out_front_value,
  output logic signed [deq_pkg::DATA_W-1:0]  out_back_value,
  output logic [deq_pkg::TOTAL_W-1:0]        out_entry_total,
  output logic                               out_is_empty,
  output logic                               out_is_full
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             ok_r;
  logic             ok_nxt;
  logic             fire;
  logic             empty;
  logic             full;

  deq_pkg::row_ctrl_t front_ctrl;
  deq_pkg::row_ctrl_t back_ctrl;

  logic signed [deq_pkg::DATA_W-1:0] front_head;
  logic signed [deq_pkg::DATA_W-1:0] back_head;
  logic [CNT_W+deq_pkg::TOTAL_W-1:0] count_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));

  always_comb begin
    front_ctrl.op   = deq_pkg::ROW_HOLD;
    front_ctrl.data = in_data_in;
    back_ctrl.op    = deq_pkg::ROW_HOLD;
    back_ctrl.data  = in_data_in;
    ok_nxt          = ok_r;
    count_nxt       = count_r;
    if (fire) begin
      ok_nxt = 1'b1;
      case (in_cmd)
        deq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            ok_nxt = 1'b0;
          end else begin
            front_ctrl.op = deq_pkg::ROW_INSERT;
            back_ctrl.op  = deq_pkg::ROW_APPEND;
            count_nxt     = count_r + CNT_W'(1);
          end
        end
        deq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            ok_nxt = 1'b0;
          end else begin
            front_ctrl.op = deq_pkg::ROW_APPEND;
            back_ctrl.op  = deq_pkg::ROW_INSERT;
            count_nxt     = count_r + CNT_W'(1);
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            ok_nxt = 1'b0;
          end else begin
            front_ctrl.op = deq_pkg::ROW_REMOVE;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            ok_nxt = 1'b0;
          end else begin
            back_ctrl.op = deq_pkg::ROW_REMOVE;
            count_nxt    = count_r - CNT_W'(1);
          end
        end
        default: ok_nxt = 1'b1;
      endcase
    end
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
  end

  deq_row #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front_row (
    .clk        (clk),
    .ctrl       (front_ctrl),
    .count      (count_r),
    .head_value (front_head)
  );

  deq_row #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_back_row (
    .clk        (clk),
    .ctrl       (back_ctrl),
    .count      (count_r),
    .head_value (back_head)
  );

  assign count_ext       = {{deq_pkg::TOTAL_W{1'b0}}, count_r};
  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_front_value = empty ? '0 : front_head;
  assign out_back_value  = empty ? '0 : back_head;
  assign out_entry_total = count_ext[deq_pkg::TOTAL_W-1:0];
  assign out_is_empty    = empty;
  assign out_is_full     = full;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(count_r) && $stable(ok_r))
    else $error("state moved while result stalled");

  a_pop_empty_fails: assert property (@(posedge clk) disable iff (!rst_n)
    fire && empty && (in_cmd == deq_pkg::CMD_POP_FRONT || in_cmd == deq_pkg::CMD_POP_BACK)
    |=> !ok_r && count_r == '0)
    else $error("pop on empty did not fail cleanly");

  a_push_full_fails: assert property (@(posedge clk) disable iff (!rst_n)
    fire && full && (in_cmd == deq_pkg::CMD_PUSH_FRONT || in_cmd == deq_pkg::CMD_PUSH_BACK)
    |=> !ok_r && count_r == CNT_W'(DEPTH))
    else $error("push on full did not fail cleanly");

endmodule
